// ----- hdl/assert_macros.svh -----
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds at every clock edge outside reset
`define SVP_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("svp assertion failed");

// consequent holds in the same cycle as the antecedent
`define SVP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svp assertion failed");

// consequent holds in the cycle after the antecedent
`define SVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svp assertion failed");

`else

`define SVP_ASSERT(lbl, clk, rst_n, expr)
`define SVP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/svp_pkg.sv -----
// shared types and constants for the spatial volume and pan block
`default_nettype none

package svp_pkg;

    localparam int VOICE_COUNT = 16;

    localparam int VOICE_W  = 4;
    localparam int COORD_W  = 24;
    localparam int YAW_W    = 16;
    localparam int RAD_W    = 23;
    localparam int VOL_W    = 15;
    localparam int PAN_W    = 7;
    localparam int CFG_IDX_W = 3;

    localparam int DIFF_W   = 25;
    localparam int SQ_W     = 50;
    localparam int M49_W    = 36;
    localparam int PROD_W   = 61;

    localparam int OPND_W   = 86;
    localparam int ROOT_W   = 43;
    localparam int REM_W    = 45;
    localparam int SQRT_STEPS = 43;

    localparam int D14_W    = 31;
    localparam int DV_W     = 27;
    localparam int PXZ_W    = 42;
    localparam int NUM_W    = 44;

    localparam int DIV_W    = 56;
    localparam int QUO_W    = 16;
    localparam int DIV_STEPS = 16;

    localparam int T_W      = 15;
    localparam int TRIG_W   = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_YAW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARING_RAD  = 3'd4;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd1048576;

    localparam logic [PAN_W-1:0] PAN_CENTER = 7'd63;
    localparam logic [PAN_W-1:0] PAN_MAX    = 7'd127;

    // quarter-wave sine polynomial coefficients, q14
    localparam logic [14:0] SIN_A = 15'd25736;
    localparam logic [13:0] SIN_B = 14'd10512;
    localparam logic [10:0] SIN_C = 11'd1160;
    localparam logic [YAW_W-1:0] QUARTER_TURN = 16'd16384;

    typedef struct packed {
        logic [OPND_W-1:0] opnd;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dsh;
        logic [QUO_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [VOL_W-1:0]   m;
        logic [DIFF_W-1:0]  dx;
        logic [DIFF_W-1:0]  dz;
        logic               szero;
    } t_sq_side;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [VOL_W-1:0]   m;
        logic               szero;
        logic               npos;
        logic               ovf_v;
        logic               ovf_p;
    } t_dv_side;

endpackage

`default_nettype wire

// ----- hdl/spatial_volume_and_pan.sv -----
// results pass stages 0-4, the root cells, stages 5-7, the divider cells and r_out
// throughput: one transaction per cycle; the pipeline freezes as a whole only
// while a finished result waits in the output register under stall
// the depth comes from 43 square-root cells and 16 divider cells in a row
// reset: synchronous active low, clears the valid bits and sets the listener
// registers to zero and the hearing radius to 4096.0
`default_nettype none
`include "assert_macros.svh"

module spatial_volume_and_pan import svp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [VOICE_W-1:0]   i_voice_index,
    input  wire logic signed [COORD_W-1:0] i_source_x,
    input  wire logic signed [COORD_W-1:0] i_source_y,
    input  wire logic signed [COORD_W-1:0] i_source_z,
    input  wire logic [VOL_W-1:0]     i_full_volume,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [VOICE_W-1:0]        o_voice_out,
    output logic [VOL_W-1:0]          o_attenuated_volume,
    output logic [PAN_W-1:0]          o_stereo_pan
);

    logic signed [COORD_W-1:0] r_lx, r_ly, r_lz;
    logic [YAW_W-1:0]          r_yaw;
    logic [RAD_W-1:0]          r_radius;

    logic w_en;

    // stage 0: offsets
    logic                     r0_vld;
    logic [VOICE_W-1:0]       r0_voice;
    logic [VOL_W-1:0]         r0_m;
    logic signed [DIFF_W-1:0] r0_dx, r0_dy, r0_dz;

    // stage 1: squares
    logic signed [SQ_W-1:0]   w_sqx, w_sqy, w_sqz;
    logic [29:0]              w_m2;
    logic                     r1_vld;
    logic [VOICE_W-1:0]       r1_voice;
    logic [VOL_W-1:0]         r1_m;
    logic [DIFF_W-1:0]        r1_dx, r1_dz;
    logic [SQ_W-1:0]          r1_sqx, r1_sqy, r1_sqz;
    logic [29:0]              r1_m2;

    // stage 2: squared distance and 49*m^2
    logic                     r2_vld;
    logic [VOICE_W-1:0]       r2_voice;
    logic [VOL_W-1:0]         r2_m;
    logic [DIFF_W-1:0]        r2_dx, r2_dz;
    logic [SQ_W-1:0]          r2_s;
    logic [M49_W-1:0]         r2_m49;

    // stage 3: partial products of 49*m^2*s
    logic [PROD_W-1:0]        w_pl, w_ph;
    logic                     r3_vld;
    t_sq_side                 r3_side;
    logic [SQ_W-1:0]          r3_s;
    logic [PROD_W-1:0]        r3_pl, r3_ph;

    // stage 4: square root operands
    logic                     r4_vld;
    t_sq_side                 r4_side;
    t_sqrt                    r4_sa, r4_sb;

    // square root chain
    t_sqrt                    w_sa [SQRT_STEPS+1];
    t_sqrt                    w_sb [SQRT_STEPS+1];
    logic [SQRT_STEPS-1:0]    r_sq_vld;
    t_sq_side                 r_sq_side [SQRT_STEPS];
    t_sq_side                 w_sql;

    // stage 5
    logic signed [TRIG_W-1:0] w_sin, w_cos;
    logic [YAW_W-1:0]         w_yaw_c;
    logic [ROOT_W:0]          w_q;
    logic [DV_W-1:0]          w_dv;
    logic signed [PXZ_W-1:0]  w_pcx, w_psz;
    logic                     r5_vld;
    t_dv_side                 r5_side;
    logic [ROOT_W:0]          r5_q;
    logic [DV_W-1:0]          r5_dv;
    logic [D14_W-1:0]         r5_d14;
    logic signed [PXZ_W-1:0]  r5_pcx, r5_psz;

    // stage 6
    logic                     r6_vld;
    t_dv_side                 r6_side;
    logic [ROOT_W:0]          r6_q;
    logic [DV_W-1:0]          r6_dv;
    logic [D14_W-1:0]         r6_d14;
    logic signed [NUM_W-1:0]  r6_num;

    // stage 7: divider operands
    logic [DIV_W-1:0]         w_n;
    logic                     r7_vld;
    t_dv_side                 r7_side;
    t_div                     r7_dva, r7_dvb;

    // divider chain
    t_div                     w_va [DIV_STEPS+1];
    t_div                     w_vb [DIV_STEPS+1];
    logic [DIV_STEPS-1:0]     r_dv_vld;
    t_dv_side                 r_dv_side [DIV_STEPS];
    t_dv_side                 w_dvl;

    // final
    logic [QUO_W:0]           w_k;
    logic [VOL_W-1:0]         w_vol;
    logic [PAN_W-1:0]         w_pan;
    logic                     r_out_valid;
    logic [VOICE_W-1:0]       r_out_voice;
    logic [VOL_W-1:0]         r_out_vol;
    logic [PAN_W-1:0]         r_out_pan;

    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx     <= '0;
            r_ly     <= '0;
            r_lz     <= '0;
            r_yaw    <= '0;
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LISTENER_X:   r_lx     <= i_cfg_wdata;
                CFG_LISTENER_Y:   r_ly     <= i_cfg_wdata;
                CFG_LISTENER_Z:   r_lz     <= i_cfg_wdata;
                CFG_LISTENER_YAW: r_yaw    <= i_cfg_wdata[YAW_W-1:0];
                CFG_HEARING_RAD:  r_radius <= i_cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // sine and cosine of the listener yaw
    assign w_yaw_c = r_yaw + QUARTER_TURN;

    svp_trig u_sin (
        .i_clk   (i_clk),
        .i_angle (r_yaw),
        .o_sin   (w_sin)
    );

    svp_trig u_cos (
        .i_clk   (i_clk),
        .i_angle (w_yaw_c),
        .o_sin   (w_cos)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld      <= 1'b0;
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r_sq_vld    <= '0;
            r5_vld      <= 1'b0;
            r6_vld      <= 1'b0;
            r7_vld      <= 1'b0;
            r_dv_vld    <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            // voices beyond the channel count give no result
            r0_vld      <= i_in_valid && (32'(i_voice_index) < VOICE_COUNT);
            r1_vld      <= r0_vld;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= r3_vld;
            r_sq_vld    <= {r_sq_vld[SQRT_STEPS-2:0], r4_vld};
            r5_vld      <= r_sq_vld[SQRT_STEPS-1];
            r6_vld      <= r5_vld;
            r7_vld      <= r6_vld;
            r_dv_vld    <= {r_dv_vld[DIV_STEPS-2:0], r7_vld};
            r_out_valid <= r_dv_vld[DIV_STEPS-1];
        end
    end

    // front stages
    assign w_sqx = r0_dx * r0_dx;
    assign w_sqy = r0_dy * r0_dy;
    assign w_sqz = r0_dz * r0_dz;
    assign w_m2  = r0_m * r0_m;
    assign w_pl  = r2_m49 * r2_s[24:0];
    assign w_ph  = r2_m49 * r2_s[SQ_W-1:25];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_voice <= i_voice_index;
            r0_m     <= i_full_volume;
            r0_dx    <= DIFF_W'(i_source_x) - DIFF_W'(r_lx);
            r0_dy    <= DIFF_W'(i_source_y) - DIFF_W'(r_ly);
            r0_dz    <= DIFF_W'(i_source_z) - DIFF_W'(r_lz);

            r1_voice <= r0_voice;
            r1_m     <= r0_m;
            r1_dx    <= r0_dx;
            r1_dz    <= r0_dz;
            r1_sqx   <= w_sqx;
            r1_sqy   <= w_sqy;
            r1_sqz   <= w_sqz;
            r1_m2    <= w_m2;

            r2_voice <= r1_voice;
            r2_m     <= r1_m;
            r2_dx    <= r1_dx;
            r2_dz    <= r1_dz;
            r2_s     <= r1_sqx + r1_sqy + r1_sqz;
            r2_m49   <= {r1_m2, 6'd0} - {2'd0, r1_m2, 4'd0} + {6'd0, r1_m2};

            r3_side.voice <= r2_voice;
            r3_side.m     <= r2_m;
            r3_side.dx    <= r2_dx;
            r3_side.dz    <= r2_dz;
            r3_side.szero <= (r2_s == '0);
            r3_s          <= r2_s;
            r3_pl         <= w_pl;
            r3_ph         <= w_ph;

            r4_side    <= r3_side;
            // 49*m^2*s for the volume, s<<12 for the q14 distance
            r4_sa.opnd <= OPND_W'(r3_pl) + {r3_ph, 25'd0};
            r4_sa.rem  <= '0;
            r4_sa.root <= '0;
            r4_sb.opnd <= {24'd0, r3_s, 12'd0};
            r4_sb.rem  <= '0;
            r4_sb.root <= '0;
        end
    end

    // square root cells
    assign w_sa[0] = r4_sa;
    assign w_sb[0] = r4_sb;

    for (genvar gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
        svp_sqrt_cell u_cell_a (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sa[gi]),
            .o_q   (w_sa[gi+1])
        );
        svp_sqrt_cell u_cell_b (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sb[gi]),
            .o_q   (w_sb[gi+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_side[gi] <= (gi == 0) ? r4_side : r_sq_side[(gi == 0) ? 0 : gi-1];
            end
        end
    end

    assign w_sql = r_sq_side[SQRT_STEPS-1];

    // ceiling square root, 10*r and the rotated offset
    assign w_q   = {1'b0, w_sa[SQRT_STEPS].root} + {ROOT_W'(0), (w_sa[SQRT_STEPS].rem != '0)};
    assign w_dv  = {1'b0, r_radius, 3'd0} + {3'd0, r_radius, 1'b0};
    assign w_pcx = w_cos * $signed(w_sql.dx);
    assign w_psz = w_sin * $signed(w_sql.dz);
    assign w_n   = {6'd0, r6_num[NUM_W-2:0], 7'd0} - {13'd0, r6_num[NUM_W-2:0]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_side.voice <= w_sql.voice;
            r5_side.m     <= w_sql.m;
            r5_side.szero <= w_sql.szero;
            r5_side.npos  <= 1'b0;
            r5_side.ovf_v <= (w_q >= {1'b0, w_dv, 16'd0});
            r5_side.ovf_p <= 1'b0;
            r5_q          <= w_q;
            r5_dv         <= w_dv;
            r5_d14        <= w_sb[SQRT_STEPS].root[D14_W-1:0];
            r5_pcx        <= w_pcx;
            r5_psz        <= w_psz;

            r6_side <= r5_side;
            r6_q    <= r5_q;
            r6_dv   <= r5_dv;
            r6_d14  <= r5_d14;
            r6_num  <= NUM_W'(r5_pcx) + NUM_W'(r5_psz) + $signed({5'd0, r5_d14, 8'd0});

            r7_side.voice <= r6_side.voice;
            r7_side.m     <= r6_side.m;
            r7_side.szero <= r6_side.szero;
            r7_side.ovf_v <= r6_side.ovf_v;
            r7_side.npos  <= !r6_num[NUM_W-1] && (r6_num != '0);
            r7_side.ovf_p <= (w_n >= {9'd0, r6_d14, 16'd0});
            r7_dva.rem    <= {12'd0, r6_q};
            r7_dva.dsh    <= {14'd0, r6_dv, 15'd0};
            r7_dva.quo    <= '0;
            r7_dvb.rem    <= w_n;
            r7_dvb.dsh    <= {1'b0, r6_d14, 24'd0};
            r7_dvb.quo    <= '0;
        end
    end

    // divider cells
    assign w_va[0] = r7_dva;
    assign w_vb[0] = r7_dvb;

    for (genvar gj = 0; gj < DIV_STEPS; gj++) begin : g_div
        svp_div_cell u_cell_v (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_va[gj]),
            .o_q   (w_va[gj+1])
        );
        svp_div_cell u_cell_p (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_vb[gj]),
            .o_q   (w_vb[gj+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_side[gj] <= (gj == 0) ? r7_side : r_dv_side[(gj == 0) ? 0 : gj-1];
            end
        end
    end

    assign w_dvl = r_dv_side[DIV_STEPS-1];

    // volume: largest v with m-v >= ceil(sqrt(49 m^2 s) / (10 r))
    assign w_k   = {1'b0, w_va[DIV_STEPS].quo}
                 + {QUO_W'(0), (w_va[DIV_STEPS].rem != '0)};
    assign w_vol = (w_dvl.ovf_v || (w_k > {2'd0, w_dvl.m})) ? '0
                 : VOL_W'({2'd0, w_dvl.m} - w_k);

    always_comb begin
        if (w_dvl.szero) begin
            w_pan = PAN_CENTER;
        end else if (!w_dvl.npos) begin
            w_pan = '0;
        end else if (w_dvl.ovf_p) begin
            w_pan = PAN_MAX;
        end else begin
            w_pan = w_vb[DIV_STEPS].quo[PAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_voice <= w_dvl.voice;
            r_out_vol   <= w_vol;
            r_out_pan   <= w_pan;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_voice_out         = r_out_voice;
    assign o_attenuated_volume = r_out_vol;
    assign o_stereo_pan        = r_out_pan;

    // a frozen pipeline keeps its transactions in place
    `SVP_ASSERT_NEXT(a_freeze_holds, i_clk, i_rst_n, !w_en, $stable(r_sq_vld) && $stable(r_dv_vld))
    // attenuation never raises the volume
    `SVP_ASSERT_IMPL(a_vol_bounded, i_clk, i_rst_n, r_dv_vld[DIV_STEPS-1], w_vol <= w_dvl.m)
    // the last divider stage always lands in the output register
    `SVP_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_dv_vld[DIV_STEPS-1] && w_en, o_out_valid)

endmodule

`default_nettype wire

// ----- hdl/svp_sqrt_cell.sv -----
// one digit step of the bit-pair integer square root chain
`default_nettype none

module svp_sqrt_cell import svp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_sqrt i_d,
    output t_sqrt      o_q
);

    logic [REM_W-1:0] w_sh;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;
    t_sqrt            n_q;
    t_sqrt            r_q;

    // bring in the next two operand bits
    assign w_sh    = {i_d.rem[REM_W-3:0], i_d.opnd[OPND_W-1 -: 2]};
    assign w_trial = {i_d.root, 2'b01};
    assign w_ge    = (w_sh >= w_trial);

    always_comb begin
        n_q.opnd = {i_d.opnd[OPND_W-3:0], 2'b00};
        n_q.rem  = w_ge ? (w_sh - w_trial) : w_sh;
        n_q.root = {i_d.root[ROOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ----- hdl/svp_div_cell.sv -----
// one quotient bit of the restoring division chain
`default_nettype none

module svp_div_cell import svp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_div i_d,
    output t_div      o_q
);

    logic w_ge;
    t_div n_q;
    t_div r_q;

    assign w_ge = (i_d.rem >= i_d.dsh);

    always_comb begin
        n_q.rem = w_ge ? (i_d.rem - i_d.dsh) : i_d.rem;
        n_q.dsh = {1'b0, i_d.dsh[DIV_W-1:1]};
        n_q.quo = {i_d.quo[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ----- hdl/svp_trig.sv -----
// pipelined q14 sine of a 16-bit turn angle, fifth-order polynomial
`default_nettype none

module svp_trig import svp_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic [YAW_W-1:0]    i_angle,
    output logic signed [TRIG_W-1:0] o_sin
);

    logic [T_W-1:0]   w_t;
    logic [29:0]      w_tt;
    logic [25:0]      w_pc;
    logic [28:0]      w_pi;
    logic [29:0]      w_ps;
    logic signed [TRIG_W-1:0] w_s;

    logic [T_W-1:0] r1_t, r1_t2;
    logic           r1_neg;
    logic [T_W-1:0] r2_t, r2_t2;
    logic [13:0]    r2_inner;
    logic           r2_neg;
    logic [T_W-1:0] r3_t, r3_x;
    logic           r3_neg;
    logic signed [TRIG_W-1:0] r4_sin;

    // odd quadrants mirror the angle
    assign w_t  = i_angle[14] ? (15'd16384 - {1'b0, i_angle[13:0]}) : {1'b0, i_angle[13:0]};
    assign w_tt = w_t * w_t;
    assign w_pc = r1_t2 * SIN_C;
    assign w_pi = r2_t2 * r2_inner;
    assign w_ps = r3_t * r3_x;
    assign w_s  = $signed({1'b0, w_ps[29:14]});

    always_ff @(posedge i_clk) begin
        r1_t     <= w_t;
        r1_t2    <= w_tt[28:14];
        r1_neg   <= i_angle[15];
        r2_t     <= r1_t;
        r2_t2    <= r1_t2;
        r2_inner <= SIN_B - {3'd0, w_pc[24:14]};
        r2_neg   <= r1_neg;
        r3_t     <= r2_t;
        r3_x     <= SIN_A - w_pi[28:14];
        r3_neg   <= r2_neg;
        r4_sin   <= r3_neg ? -w_s : w_s;
    end

    assign o_sin = r4_sin;

endmodule

`default_nettype wire
